// ===== rtl/core/gkm_pkg.sv =====
// ----------------------------------------------------------------------------
// gkm_pkg
// Shared types, codes and helpers of the gapped keyword matcher.
// ----------------------------------------------------------------------------
package gkm_pkg;

  localparam int unsigned SYM_W         = 21;
  localparam int unsigned PATTERN_CHARS = 32;
  localparam int unsigned CASE_DIST     = 32;
  localparam int unsigned SKIP_TOP      = 126;
  localparam int unsigned GAP_RESET     = 20;
  localparam logic [19:0] COUNTER_MAX   = 20'hFFFFF;

  typedef enum logic [2:0] {
    FN_PAT_CHAR = 3'd0,
    FN_PAT_LEN  = 3'd1,
    FN_NEW_LINE = 3'd2,
    FN_TXT_CHAR = 3'd3,
    FN_SCAN     = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // one text character moving down the cell chain
  typedef struct packed {
    logic             valid;
    logic             first;
    logic [SYM_W-1:0] sym;
  } stream_t;

  // pattern table write request, broadcast to all cells
  typedef struct packed {
    logic             we_char;
    logic             we_len;
    logic [3:0]       slot;
    logic [4:0]       cidx;
    logic [SYM_W-1:0] sym;
    logic [5:0]       len;
  } pat_wr_t;

  // scan control, broadcast to all cells
  typedef struct packed {
    logic       clear;
    logic       col_ok;
    logic [4:0] pattern_count;
    logic [7:0] max_gap;
  } scan_ctl_t;

  function automatic logic is_letter(input logic [SYM_W-1:0] c);
    return ((c >= SYM_W'(97)) && (c <= SYM_W'(122))) ||
           ((c >= SYM_W'(65)) && (c <= SYM_W'(90)));
  endfunction

  function automatic logic sym_equal(input logic [SYM_W-1:0] p,
                                     input logic [SYM_W-1:0] t,
                                     input logic             fold);
    logic [SYM_W:0] pe;
    logic [SYM_W:0] te;
    pe = {1'b0, p};
    te = {1'b0, t};
    if (p == t) return 1'b1;
    if (!fold) return 1'b0;
    if (pe == te + (SYM_W+1)'(CASE_DIST)) return 1'b1;
    return (te >= (SYM_W+1)'(CASE_DIST)) && (pe == te - (SYM_W+1)'(CASE_DIST));
  endfunction

endpackage

// ===== rtl/core/gapped_keyword_matcher_core.sv =====
// ----------------------------------------------------------------------------
// gapped_keyword_matcher_core
// Keyword table and text line; a scan streams the line from the start column
// down a chain of slot cells and reports each matching slot in order.
// ----------------------------------------------------------------------------
// Loads (pattern char, length, new line, text char) leave busy low.
// Scan: the line RAM is read one character per cycle into the chain of slot
// cells, and the results follow back to back once the chain has drained.
// Results appear as one-cycle out_valid strobes; the receiver cannot stall.
// Reset (rst_n low, synchronous): counters, fill, lengths and registers cleared,
// max_gap to 20; pattern and line RAM contents are left as they are.
module gapped_keyword_matcher_core #(
  parameter int unsigned PATTERN_SLOTS = 16,
  parameter int unsigned LINE_CHARS    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [4:0]  in_char_index,
  input  logic [20:0] in_symbol,
  input  logic [5:0]  in_pattern_length,
  input  logic [7:0]  in_start_column,
  output logic        out_valid,
  output logic        out_matched,
  output logic [19:0] out_line_number,
  output logic [3:0]  out_match_slot,
  output logic [7:0]  out_match_column,
  output logic [7:0]  out_span_length,
  output logic [19:0] out_running_total,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gkm_pkg::*;

  localparam int unsigned NCELL = (PATTERN_SLOTS > 16) ? 16 : PATTERN_SLOTS;
  localparam int unsigned LAW   = $clog2(LINE_CHARS);
  localparam int unsigned LFW   = $clog2(LINE_CHARS + 1);
  localparam int unsigned CW    = (LFW > 8) ? LFW : 8;
  localparam int unsigned DRN   = NCELL + 2;
  localparam int unsigned DW    = $clog2(DRN + 1);
  localparam int unsigned SW    = (NCELL > 1) ? $clog2(NCELL) : 1;

  state_t           state_r, state_nxt;
  logic [4:0]       pcount_r;
  logic [7:0]       max_gap_r;
  logic [LFW-1:0]   fill_r;
  logic [19:0]      line_cnt_r;
  logic [19:0]      match_cnt_r, match_cnt_nxt;
  logic [LFW-1:0]   pos_r, pos_nxt;
  logic [7:0]       col_r;
  logic [DW-1:0]    drn_r, drn_nxt;
  logic [NCELL-1:0] pend_r, pend_nxt;
  logic             rd_v_r, rd_first_r;
  logic [SYM_W-1:0] line_q;

  logic             accept, scan_go, col_ok;
  logic             cfg_we;
  pat_wr_t          pwr;
  scan_ctl_t        ctl;
  stream_t          strm [NCELL];
  logic [NCELL-1:0] hits;
  logic [LFW-1:0]   spans [NCELL];
  logic [SW-1:0]    sel;
  logic [LFW-1:0]   sel_span;

  logic             ov_nxt, om_nxt, olast_nxt;
  logic [3:0]       oslot_nxt;
  logic [7:0]       ospan_nxt;

  assign accept  = start && !busy;
  assign scan_go = accept && (func_t'(in_func) == FN_SCAN);
  assign col_ok  = CW'(in_start_column) < CW'(fill_r);
  assign busy    = (state_r != ST_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[2] ? {24'd0, max_gap_r} : {27'd0, pcount_r};

  assign pwr.we_char = accept && (func_t'(in_func) == FN_PAT_CHAR);
  assign pwr.we_len  = accept && (func_t'(in_func) == FN_PAT_LEN);
  assign pwr.slot    = in_slot;
  assign pwr.cidx    = in_char_index;
  assign pwr.sym     = in_symbol;
  assign pwr.len     = in_pattern_length;

  assign ctl.clear         = scan_go;
  assign ctl.col_ok        = col_ok;
  assign ctl.pattern_count = pcount_r;
  assign ctl.max_gap       = max_gap_r;

  gkm_ram #(.WIDTH(SYM_W), .DEPTH(LINE_CHARS)) u_line (
    .clk   (clk),
    .we    (accept && (func_t'(in_func) == FN_TXT_CHAR) &&
            (fill_r < LFW'(LINE_CHARS))),
    .waddr (LAW'(fill_r)),
    .wdata (in_symbol),
    .raddr (LAW'(pos_r)),
    .rdata (line_q)
  );

  assign strm[0].valid = rd_v_r;
  assign strm[0].first = rd_first_r;
  assign strm[0].sym   = line_q;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    if (j < NCELL - 1) begin : g_mid
      gkm_cell #(.IDX(j), .LFW(LFW)) u_cell (
        .clk (clk), .rst_n (rst_n), .wr (pwr), .ctl (ctl),
        .cin (strm[j]), .cout (strm[j+1]), .hit (hits[j]), .span (spans[j])
      );
    end else begin : g_end
      gkm_cell #(.IDX(j), .LFW(LFW)) u_cell (
        .clk (clk), .rst_n (rst_n), .wr (pwr), .ctl (ctl),
        .cin (strm[j]), .cout (), .hit (hits[j]), .span (spans[j])
      );
    end
  end

  // lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = NCELL - 1; i >= 0; i--) begin
      if (pend_r[i]) sel = SW'(i);
    end
    sel_span = spans[sel];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (scan_go) state_nxt = col_ok ? ST_STREAM : ST_DRAIN;
      ST_STREAM: if (LFW'(pos_r + 1'b1) == fill_r) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (drn_r == DW'(DRN)) state_nxt = ST_EMIT;
      ST_EMIT:   if ((pend_r & ~(NCELL'(1) << sel)) == '0) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pos_nxt       = pos_r;
    drn_nxt       = '0;
    pend_nxt      = pend_r;
    match_cnt_nxt = match_cnt_r;
    ov_nxt        = 1'b0;
    om_nxt        = 1'b0;
    olast_nxt     = 1'b0;
    oslot_nxt     = '0;
    ospan_nxt     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (scan_go) pos_nxt = LFW'(in_start_column);
      end
      ST_STREAM: begin
        pos_nxt = LFW'(pos_r + 1'b1);
      end
      ST_DRAIN: begin
        drn_nxt  = DW'(drn_r + 1'b1);
        pend_nxt = hits;
      end
      ST_EMIT: begin
        ov_nxt = 1'b1;
        if (pend_r == '0) begin
          olast_nxt = 1'b1;
        end else begin
          pend_nxt  = pend_r & ~(NCELL'(1) << sel);
          om_nxt    = 1'b1;
          olast_nxt = (pend_nxt == '0);
          oslot_nxt = 4'(sel);
          ospan_nxt = (sel_span > LFW'(255)) ? 8'd255 : sel_span[7:0];
          if (match_cnt_r != COUNTER_MAX) match_cnt_nxt = match_cnt_r + 20'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pcount_r    <= '0;
      max_gap_r   <= 8'(GAP_RESET);
      fill_r      <= '0;
      line_cnt_r  <= '0;
      match_cnt_r <= '0;
      drn_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      match_cnt_r <= match_cnt_nxt;
      drn_r       <= drn_nxt;
      rd_v_r      <= (state_r == ST_STREAM);
      out_valid   <= ov_nxt;
      if (cfg_we && !paddr[2]) pcount_r  <= pwdata[4:0];
      if (cfg_we && paddr[2])  max_gap_r <= pwdata[7:0];
      if (accept && (func_t'(in_func) == FN_NEW_LINE)) begin
        fill_r <= '0;
        if (line_cnt_r != COUNTER_MAX) line_cnt_r <= line_cnt_r + 20'd1;
      end
      if (accept && (func_t'(in_func) == FN_TXT_CHAR) &&
          (fill_r < LFW'(LINE_CHARS))) begin
        fill_r <= LFW'(fill_r + 1'b1);
      end
    end
    pos_r      <= pos_nxt;
    pend_r     <= pend_nxt;
    rd_first_r <= (state_r == ST_STREAM) && (CW'(pos_r) == CW'(col_r));
    if (scan_go) begin
      col_r <= in_start_column;
    end
    out_matched       <= om_nxt;
    out_last          <= olast_nxt;
    out_match_slot    <= oslot_nxt;
    out_span_length   <= ospan_nxt;
    out_match_column  <= col_r;
    out_line_number   <= line_cnt_r;
    out_running_total <= match_cnt_nxt;
  end

endmodule

// ===== rtl/core/gkm_ram.sv =====
// ----------------------------------------------------------------------------
// gkm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gkm_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gkm_cell.sv =====
// ----------------------------------------------------------------------------
// gkm_cell
// One pattern slot: holds the pattern and its length, matches the text
// stream one character a cycle and passes the character to the next cell.
// ----------------------------------------------------------------------------
module gkm_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LFW = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gkm_pkg::pat_wr_t  wr,
  input  gkm_pkg::scan_ctl_t ctl,
  input  gkm_pkg::stream_t  cin,
  output gkm_pkg::stream_t  cout,
  output logic              hit,
  output logic [LFW-1:0]    span
);
  import gkm_pkg::*;

  localparam int unsigned CAW = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;

  logic [5:0]       plen_r, plen_nxt;
  logic [5:0]       k_r, k_nxt;
  logic [LFW-1:0]   len_r, len_nxt;
  logic [8:0]       gaps_r, gaps_nxt;
  logic             run_r, run_nxt;
  logic             hit_r, hit_nxt;
  logic             fold_r, fold_nxt;
  stream_t          cout_r;
  logic [SYM_W-1:0] pat_q;
  logic             fold_now;
  logic             en;

  gkm_ram #(.WIDTH(SYM_W), .DEPTH(PATTERN_CHARS)) u_pat (
    .clk   (clk),
    .we    (wr.we_char && (wr.slot == 4'(IDX)) && (32'(wr.cidx) < PATTERN_CHARS)),
    .waddr (CAW'(wr.cidx)),
    .wdata (wr.sym),
    .raddr (CAW'(k_nxt)),
    .rdata (pat_q)
  );

  assign en       = ctl.col_ok && (5'(IDX) < ctl.pattern_count);
  assign fold_now = cin.first ? is_letter(cin.sym) : fold_r;

  always_comb begin
    plen_nxt = plen_r;
    k_nxt    = k_r;
    len_nxt  = len_r;
    gaps_nxt = gaps_r;
    run_nxt  = run_r;
    hit_nxt  = hit_r;
    fold_nxt = fold_r;
    if (wr.we_len && (wr.slot == 4'(IDX))) begin
      plen_nxt = (32'(wr.len) > PATTERN_CHARS) ? 6'(PATTERN_CHARS) : wr.len;
    end
    if (ctl.clear) begin
      k_nxt    = '0;
      len_nxt  = '0;
      gaps_nxt = '0;
      run_nxt  = en && (plen_r != '0);
      hit_nxt  = en && (plen_r == '0);
    end else if (cin.valid) begin
      fold_nxt = fold_now;
      if (run_r) begin
        if (sym_equal(pat_q, cin.sym, fold_now)) begin
          k_nxt    = k_r + 6'd1;
          len_nxt  = len_r + 1'b1;
          gaps_nxt = '0;
          if (k_nxt == plen_r) begin
            run_nxt = 1'b0;
            hit_nxt = 1'b1;
          end
        end else if ((cin.sym <= SYM_W'(SKIP_TOP)) && !is_letter(cin.sym) &&
                     (k_r != '0)) begin
          len_nxt  = len_r + 1'b1;
          gaps_nxt = gaps_r + 9'd1;
          if (gaps_nxt > {1'b0, ctl.max_gap}) begin
            run_nxt = 1'b0;
          end
        end else begin
          run_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r       <= '0;
      k_r          <= '0;
      run_r        <= 1'b0;
      hit_r        <= 1'b0;
      cout_r.valid <= 1'b0;
    end else begin
      plen_r       <= plen_nxt;
      k_r          <= k_nxt;
      run_r        <= run_nxt;
      hit_r        <= hit_nxt;
      cout_r.valid <= cin.valid;
    end
    len_r        <= len_nxt;
    gaps_r       <= gaps_nxt;
    fold_r       <= fold_nxt;
    cout_r.first <= cin.first;
    cout_r.sym   <= cin.sym;
  end

  assign cout = cout_r;
  assign hit  = hit_r;
  assign span = len_r;

endmodule

// ===== verif/gkm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gkm_checker
// Watches the request, result and register ports of the keyword matcher,
// predicts the result stream of every scan and compares it field by field.
// ----------------------------------------------------------------------------
module gkm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [4:0]  in_char_index,
  input  logic [20:0] in_symbol,
  input  logic [5:0]  in_pattern_length,
  input  logic [7:0]  in_start_column,
  input  logic        out_valid,
  input  logic        out_matched,
  input  logic [19:0] out_line_number,
  input  logic [3:0]  out_match_slot,
  input  logic [7:0]  out_match_column,
  input  logic [7:0]  out_span_length,
  input  logic [19:0] out_running_total,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import gkm_pkg::*;

  localparam logic [2:0] ADDR_PATTERN_COUNT = 3'd0;
  localparam logic [2:0] ADDR_MAX_GAP       = 3'd4;
  localparam int NUM_SLOTS = 16;
  localparam int NUM_CHARS = 32;
  localparam int LINE_LEN  = 256;

  typedef struct packed {
    logic        matched;
    logic [19:0] line_number;
    logic [3:0]  slot;
    logic [7:0]  column;
    logic [7:0]  span;
    logic [19:0] total;
    logic        last;
  } match_rec_t;

  match_rec_t       hits_q[$];
  logic [20:0]      pat_mem[NUM_SLOTS][NUM_CHARS];
  logic [5:0]       pat_len[NUM_SLOTS];
  logic [20:0]      line_mem[LINE_LEN];
  int unsigned      fill;
  logic [19:0]      line_cnt;
  logic [19:0]      match_cnt;
  logic [4:0]       slots_used;
  logic [7:0]       gap_limit;

  function automatic bit letter(int unsigned c);
    return (c >= 97 && c <= 122) || (c >= 65 && c <= 90);
  endfunction

  function automatic bit sym_hit(int unsigned p, int unsigned t, bit fold);
    if (p == t) return 1'b1;
    if (!fold) return 1'b0;
    return (p == t + CASE_DIST) || (t >= CASE_DIST && p == t - CASE_DIST);
  endfunction

  // walks one pattern over the line; skippable chars only after the first hit
  function automatic bit slot_hits(int s, int col, output int span);
    int unsigned k, len, gaps, t;
    bit fold;
    k = 0;
    len = 0;
    gaps = 0;
    fold = letter(line_mem[col]);
    while (k < pat_len[s] && col + len < fill) begin
      t = line_mem[col + len];
      if (sym_hit(pat_mem[s][k], t, fold)) begin
        k++;
        len++;
        gaps = 0;
      end else if (t <= SKIP_TOP && !letter(t) && k != 0) begin
        len++;
        gaps++;
        if (gaps > gap_limit) break;
      end else begin
        break;
      end
    end
    span = len;
    return k == pat_len[s];
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      fail_count++;
    end
  endtask

  task automatic predict_scan(int col);
    int limit, n, span;
    match_rec_t r;
    limit = slots_used > NUM_SLOTS ? NUM_SLOTS : slots_used;
    n = 0;
    if (col < fill) begin
      for (int s = 0; s < limit; s++) begin
        if (slot_hits(s, col, span)) begin
          if (match_cnt < COUNTER_MAX) match_cnt++;
          r = '{1'b1, line_cnt, 4'(s), 8'(col), (span > 255) ? 8'd255 : 8'(span),
                match_cnt, 1'b0};
          hits_q.push_back(r);
          n++;
        end
      end
    end
    if (n == 0) begin
      r = '{1'b0, line_cnt, 4'd0, 8'(col), 8'd0, match_cnt, 1'b1};
      hits_q.push_back(r);
    end else begin
      hits_q[hits_q.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    match_rec_t e;
    if (!rst_n) begin
      hits_q.delete();
      foreach (pat_len[i]) pat_len[i] = '0;
      fill = 0;
      line_cnt = '0;
      match_cnt = '0;
      slots_used = '0;
      gap_limit = 8'(GAP_RESET);
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (hits_q.size() == 0) begin
          $error("result with no scan outstanding");
          fail_count++;
        end else begin
          e = hits_q.pop_front();
          check_field("matched", e.matched, out_matched);
          check_field("line_number", e.line_number, out_line_number);
          check_field("match_slot", e.slot, out_match_slot);
          check_field("match_column", e.column, out_match_column);
          check_field("span_length", e.span, out_span_length);
          check_field("running_total", e.total, out_running_total);
          check_field("last", e.last, out_last);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_PATTERN_COUNT) slots_used = pwdata[4:0];
        else if (paddr == ADDR_MAX_GAP) gap_limit = pwdata[7:0];
      end
      if (start && !busy) begin
        case (in_func)
          FN_PAT_CHAR: pat_mem[in_slot][in_char_index] = in_symbol;
          FN_PAT_LEN:  pat_len[in_slot] = (in_pattern_length > NUM_CHARS) ?
                                          6'(NUM_CHARS) : in_pattern_length;
          FN_NEW_LINE: begin
            if (line_cnt < COUNTER_MAX) line_cnt++;
            fill = 0;
          end
          FN_TXT_CHAR: begin
            if (fill < LINE_LEN) begin
              line_mem[fill] = in_symbol;
              fill++;
            end
          end
          FN_SCAN:     predict_scan(in_start_column);
          default: ;
        endcase
      end
    end
    pending = hits_q.size();
  end

endmodule

// ===== verif/tb_gapped_keyword_matcher_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gapped_keyword_matcher_core
// Drives pattern loads, text lines and column scans under several register
// settings, with random idle cycles; a checker beside the core scores results.
// ----------------------------------------------------------------------------
module tb_gapped_keyword_matcher_core;
  import gkm_pkg::*;

  localparam logic [2:0] ADDR_PATTERN_COUNT = 3'd0;
  localparam logic [2:0] ADDR_MAX_GAP       = 3'd4;
  localparam logic [2:0] FN_RESERVED_A      = 3'd5;
  localparam logic [2:0] FN_RESERVED_B      = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_func = '0;
  logic [3:0]  in_slot = '0;
  logic [4:0]  in_char_index = '0;
  logic [20:0] in_symbol = '0;
  logic [5:0]  in_pattern_length = '0;
  logic [7:0]  in_start_column = '0;
  logic        out_valid, out_matched, out_last;
  logic [19:0] out_line_number, out_running_total;
  logic [3:0]  out_match_slot;
  logic [7:0]  out_match_column, out_span_length;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          cycles = 0;
  int          sent = 0;
  bit          no_idle = 1'b0;
  bit          written[16][32];
  int          fill = 0;

  gapped_keyword_matcher_core uut (.*);

  gkm_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_gapped_keyword_matcher_core NOT OK");
      $finish;
    end
  end

  // all tasks start and end just after a falling edge
  task automatic send(logic [2:0] f, logic [3:0] s, logic [4:0] ci, logic [20:0] sym,
                      logic [5:0] pl, logic [7:0] col);
    if (!no_idle && $urandom_range(99) < 21) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_func = f;
    in_slot = s;
    in_char_index = ci;
    in_symbol = sym;
    in_pattern_length = pl;
    in_start_column = col;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    sent++;
    if (f == FN_PAT_CHAR) written[s][ci] = 1'b1;
    if (f == FN_NEW_LINE) fill = 0;
    if (f == FN_TXT_CHAR && fill < 256) fill++;
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // no register write while a scan is still walking the line
  task automatic settle();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_regs(int slots, int gap);
    settle();
    reg_write(ADDR_PATTERN_COUNT, slots);
    reg_write(ADDR_MAX_GAP, gap);
  endtask

  function automatic int prefix(int s);
    int n;
    n = 0;
    while (n < 32 && written[s][n]) n++;
    return n;
  endfunction

  function automatic logic [20:0] pick_text();
    case ($urandom_range(0, 13))
      0, 7:  return 21'd97;
      1, 8:  return 21'd98;
      2:     return 21'd99;
      3, 9:  return 21'd65;
      4:     return 21'd66;
      5, 10: return 21'd32;
      6:     return 21'd45;
      11:    return $urandom_range(0, 1) ? 21'd0 : 21'd126;
      12:    return 21'd127;
      default: return 21'($urandom_range(0, 1114111));
    endcase
  endfunction

  function automatic logic [20:0] pick_pat();
    case ($urandom_range(0, 7))
      0, 1: return 21'd97;
      2, 3: return 21'd66;
      4:    return 21'd99;
      5:    return 21'd65;
      6:    return 21'd45;
      default: return pick_text();
    endcase
  endfunction

  task automatic define_pattern(int s, int n);
    int plen;
    for (int i = 0; i < n; i++) send(FN_PAT_CHAR, 4'(s), 5'(i), pick_pat(), '0, '0);
    plen = (n == 32 && $urandom_range(0, 1)) ? $urandom_range(33, 63) : n;
    send(FN_PAT_LEN, 4'(s), '0, '0, 6'(plen), '0);
  endtask

  task automatic random_part(int count);
    int target, s, p, c;
    target = sent + count;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0, 1: define_pattern($urandom_range(0, 15),
                             $urandom_range(0, 9) == 0 ? 32 : $urandom_range(0, 5));
        2, 3: begin
          send(FN_NEW_LINE, '0, '0, '0, '0, '0);
          repeat ($urandom_range(3, 18)) send(FN_TXT_CHAR, '0, '0, pick_text(), '0, '0);
        end
        4: begin
          // noise: stray pattern char, pattern length and text char loads
          case ($urandom_range(0, 2))
            0: send(FN_PAT_CHAR, 4'($urandom), 5'($urandom),
                    21'($urandom_range(0, 1114111)), '0, '0);
            1: begin
              s = $urandom_range(0, 15);
              p = prefix(s);
              send(FN_PAT_LEN, 4'(s), '0, '0,
                   6'(p == 32 ? $urandom_range(0, 63) : $urandom_range(0, p)), '0);
            end
            default: send(FN_TXT_CHAR, '0, '0, pick_text(), '0, '0);
          endcase
        end
        default: begin
          c = $urandom_range(0, 15) == 0 ? $urandom_range(0, 255)
                                         : $urandom_range(0, fill + 1);
          send(FN_SCAN, '0, '0, '0, '0, 8'(c));
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: "cat" folded against "C- AT", empty slot, top symbol
    set_regs(16, 20);
    send(FN_PAT_CHAR, 4'd0, 5'd0, 21'd99, '0, '0);
    send(FN_PAT_CHAR, 4'd0, 5'd1, 21'd97, '0, '0);
    send(FN_PAT_CHAR, 4'd0, 5'd2, 21'd116, '0, '0);
    send(FN_PAT_LEN, 4'd0, '0, '0, 6'd3, '0);
    send(FN_PAT_LEN, 4'd1, '0, '0, 6'd0, '0);
    send(FN_PAT_CHAR, 4'd15, 5'd31, 21'h1FFFFF, '0, '0);
    send(FN_PAT_CHAR, 4'd2, 5'd0, 21'd1114111, '0, '0);
    send(FN_PAT_LEN, 4'd2, '0, '0, 6'd1, '0);
    send(FN_NEW_LINE, '0, '0, '0, '0, '0);
    send(FN_TXT_CHAR, '0, '0, 21'd67, '0, '0);
    send(FN_TXT_CHAR, '0, '0, 21'd45, '0, '0);
    send(FN_TXT_CHAR, '0, '0, 21'd32, '0, '0);
    send(FN_TXT_CHAR, '0, '0, 21'd65, '0, '0);
    send(FN_TXT_CHAR, '0, '0, 21'd84, '0, '0);
    send(FN_TXT_CHAR, '0, '0, 21'd1114111, '0, '0);
    send(FN_SCAN, '0, '0, '0, '0, 8'd0);
    send(FN_SCAN, '0, '0, '0, '0, 8'd5);
    send(FN_SCAN, '0, '0, '0, '0, 8'd1);
    send(FN_SCAN, '0, '0, '0, '0, 8'd255);
    send(FN_RESERVED_A, 4'd15, 5'd31, 21'h1FFFFF, 6'd63, 8'd255);
    send(FN_RESERVED_B, '0, '0, '0, '0, '0);
    set_regs(16, 0);
    send(FN_SCAN, '0, '0, '0, '0, 8'd0);

    set_regs(16, 255);
    define_pattern(15, 32);
    random_part(20);
    set_regs(0, 0);
    random_part(8);
    set_regs(7, 0);
    random_part(15);
    set_regs(16, 3);
    no_idle = 1'b1;
    random_part(25);
    no_idle = 1'b0;
    random_part(12);

    // full line: 'a', 254 blanks, 'B', then dropped chars; span saturates
    set_regs(16, 254);
    send(FN_PAT_CHAR, 4'd3, 5'd0, 21'd97, '0, '0);
    send(FN_PAT_CHAR, 4'd3, 5'd1, 21'd98, '0, '0);
    send(FN_PAT_LEN, 4'd3, '0, '0, 6'd2, '0);
    send(FN_NEW_LINE, '0, '0, '0, '0, '0);
    send(FN_TXT_CHAR, '0, '0, 21'd97, '0, '0);
    repeat (254) send(FN_TXT_CHAR, '0, '0, 21'd32, '0, '0);
    repeat (4) send(FN_TXT_CHAR, '0, '0, 21'd66, '0, '0);
    send(FN_SCAN, '0, '0, '0, '0, 8'd0);
    send(FN_SCAN, '0, '0, '0, '0, 8'd255);
    send(FN_SCAN, '0, '0, '0, '0, 8'd128);

    settle();
    if (fail_count == 0) begin
      $display("tb_gapped_keyword_matcher_core OK");
    end else begin
      $display("tb_gapped_keyword_matcher_core NOT OK");
    end
    $finish;
  end

endmodule
